// File: src/rpld_pkg.sv
`default_nettype none
package rpld_pkg;

	localparam int TABLE_SYMBOLS = 64;
	localparam int CHANNELS      = 3;
	localparam int SYMBOL_BITS   = 10;
	localparam int LENGTH_BITS   = 13;
	localparam int TABLE_TOTAL   = CHANNELS * 2 * TABLE_SYMBOLS;
	localparam int TABLE_AW      = $clog2(TABLE_TOTAL);
	localparam int INDEX_BITS    = $clog2(TABLE_SYMBOLS);

	localparam logic [31:0] PIXEL_PREFIX = 32'hC000_0000;
	localparam logic [31:0] RLE_PREFIX   = 32'h4000_0000;

	localparam logic FUNC_TABLE = 1'b0;
	localparam logic FUNC_LINE  = 1'b1;

	// one queued input transaction
	typedef struct packed {
		logic        func;
		logic [31:0] stream_word;
		logic        first;
	} entry_t;

	// queue head as seen by the decode engine
	typedef struct packed {
		logic   valid;
		entry_t entry;
	} head_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TABLE,
		ST_LINE,
		ST_LOOK,
		ST_TERM,
		ST_FLUSH
	} state_t;

endpackage
`default_nettype wire

// File: src/rpld_front.sv
`default_nettype none
module rpld_front import rpld_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	output logic        in_stall,
	input  wire entry_t in_entry,
	output head_t       head,
	input  wire logic   pop
);

	entry_t     slot_q [2];
	logic       rd_ptr_q;
	logic       wr_ptr_q;
	logic [1:0] count_q;
	logic       push;

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign head.valid = (count_q != 2'd0);
	assign head.entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: src/rpld_back.sv
`default_nettype none
module rpld_back import rpld_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire head_t  head,
	output logic        pop,
	output logic        out_valid,
	input  wire logic   out_stall,
	output logic [31:0] command,
	output logic [1:0]  chan,
	output logic        channel_end,
	output logic        item_last
);

	state_t       state_q, state_d;
	logic [63:0]  win_q, win_d;
	logic [6:0]   held_q, held_d;
	logic [8:0]   fill_q, fill_d;
	logic [1:0]   chan_q, chan_d;
	logic [LENGTH_BITS-1:0] rem_q, rem_d;
	logic         await_q, await_d;
	logic         tbl_q, tbl_d;

	logic [SYMBOL_BITS-1:0] mem0 [TABLE_TOTAL];
	logic [SYMBOL_BITS-1:0] mem1 [TABLE_TOTAL];
	logic [SYMBOL_BITS-1:0] mem2 [TABLE_TOTAL];
	logic [SYMBOL_BITS-1:0] rd0_q, rd1_q, rd2_q;
	logic                   we, rd_en;
	logic [TABLE_AW-1:0]    rd_addr0, rd_addr1, rd_addr2;

	logic        pend_v_q;
	logic [31:0] pend_cmd_q;
	logic [1:0]  pend_chan_q;
	logic        pend_end_q;

	logic        emit_req, flush_req, out_free, can_go, out_load, out_last;
	logic [31:0] emit_cmd;
	logic        emit_end;
	logic [63:0] base_w;
	logic [6:0]  base_h;
	logic [1:0]  eff_chan;
	logic [2:0]  chan_inc;
	logic [31:0] look_cmd;
	logic [LENGTH_BITS-1:0] rem_lit, rem_cmp;

	assign out_free = !out_valid || !out_stall;
	assign can_go   = !pend_v_q || out_free;
	assign chan_inc = {1'b0, chan_q} + 3'd1;
	assign rem_lit  = (rem_q > LENGTH_BITS'(32)) ? rem_q - LENGTH_BITS'(32) : '0;
	assign rem_cmp  = (rem_q > LENGTH_BITS'(20)) ? rem_q - LENGTH_BITS'(20) : '0;
	assign look_cmd = (tbl_q ? RLE_PREFIX : PIXEL_PREFIX)
		| {2'b00, rd2_q, rd1_q, rd0_q};

	// table address: channel, table select, symbol index
	assign rd_addr0 = {chan_q, !win_q[63], win_q[49:44]};
	assign rd_addr1 = {chan_q, !win_q[63], win_q[55:50]};
	assign rd_addr2 = {chan_q, !win_q[63], win_q[61:56]};

	always_comb begin
		state_d   = state_q;
		win_d     = win_q;
		held_d    = held_q;
		fill_d    = fill_q;
		chan_d    = chan_q;
		rem_d     = rem_q;
		await_d   = await_q;
		tbl_d     = tbl_q;
		pop       = 1'b0;
		we        = 1'b0;
		rd_en     = 1'b0;
		emit_req  = 1'b0;
		flush_req = 1'b0;
		emit_cmd  = '0;
		emit_end  = 1'b0;
		base_w    = head.entry.first ? '0 : win_q;
		base_h    = head.entry.first ? '0 : held_q;
		eff_chan  = head.entry.first ? '0 : chan_q;
		case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					if (head.entry.first) begin
						fill_d  = '0;
						chan_d  = '0;
						rem_d   = '0;
						await_d = 1'b1;
					end
					win_d  = base_w;
					held_d = base_h;
					if (head.entry.func == FUNC_TABLE) begin
						win_d   = base_w | ({head.entry.stream_word, 32'h0} >> base_h);
						held_d  = base_h + 7'd32;
						state_d = ST_TABLE;
					end else if ({1'b0, eff_chan} < 3'(CHANNELS)) begin
						win_d   = base_w | ({head.entry.stream_word, 32'h0} >> base_h);
						held_d  = base_h + 7'd32;
						state_d = ST_LINE;
					end
				end
			end
			ST_TABLE: begin
				if (held_q >= 7'(SYMBOL_BITS)) begin
					win_d  = win_q << SYMBOL_BITS;
					held_d = held_q - 7'(SYMBOL_BITS);
					if (fill_q < 9'(TABLE_TOTAL)) begin
						we     = 1'b1;
						fill_d = fill_q + 9'd1;
					end
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_LINE: begin
				if (await_q) begin
					if (held_q >= 7'(LENGTH_BITS)) begin
						rem_d   = win_q[63 -: LENGTH_BITS];
						win_d   = win_q << LENGTH_BITS;
						held_d  = held_q - 7'(LENGTH_BITS);
						await_d = 1'b0;
					end else begin
						state_d = ST_FLUSH;
					end
				end else if (held_q < 7'd32) begin
					state_d = ST_FLUSH;
				end else if (win_q[62]) begin
					emit_req = 1'b1;
					emit_cmd = win_q[63:32];
					if (can_go) begin
						win_d  = win_q << 32;
						held_d = held_q - 7'd32;
						rem_d  = rem_lit;
						if (rem_lit == '0) begin
							state_d = ST_TERM;
						end
					end
				end else begin
					rd_en   = 1'b1;
					tbl_d   = !win_q[63];
					win_d   = win_q << 20;
					held_d  = held_q - 7'd20;
					rem_d   = rem_cmp;
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				emit_req = 1'b1;
				emit_cmd = look_cmd;
				if (can_go) begin
					state_d = ST_LINE;
				end
			end
			ST_TERM: begin
				emit_req = 1'b1;
				emit_end = 1'b1;
				if (can_go) begin
					chan_d  = chan_inc[1:0];
					await_d = 1'b1;
					if (chan_inc >= 3'(CHANNELS)) begin
						win_d   = '0;
						held_d  = '0;
						state_d = ST_FLUSH;
					end else begin
						state_d = ST_LINE;
					end
				end
			end
			ST_FLUSH: begin
				flush_req = 1'b1;
				if (can_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		out_load = pend_v_q && can_go && (emit_req || flush_req);
		out_last = flush_req;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem0[fill_q] <= win_q[63 -: SYMBOL_BITS];
			mem1[fill_q] <= win_q[63 -: SYMBOL_BITS];
			mem2[fill_q] <= win_q[63 -: SYMBOL_BITS];
		end
		if (rd_en) begin
			rd0_q <= mem0[rd_addr0];
			rd1_q <= mem1[rd_addr1];
			rd2_q <= mem2[rd_addr2];
		end
	end

	always_ff @(posedge clk) begin
		if (emit_req && can_go) begin
			pend_cmd_q  <= emit_cmd;
			pend_chan_q <= chan_q;
			pend_end_q  <= emit_end;
		end
		if (out_load) begin
			command     <= pend_cmd_q;
			chan        <= pend_chan_q;
			channel_end <= pend_end_q;
			item_last   <= out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			win_q     <= '0;
			held_q    <= '0;
			fill_q    <= '0;
			chan_q    <= '0;
			rem_q     <= '0;
			await_q   <= 1'b1;
			tbl_q     <= 1'b0;
			pend_v_q  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			win_q   <= win_d;
			held_q  <= held_d;
			fill_q  <= fill_d;
			chan_q  <= chan_d;
			rem_q   <= rem_d;
			await_q <= await_d;
			tbl_q   <= tbl_d;
			if (emit_req && can_go) begin
				pend_v_q <= 1'b1;
			end else if (flush_req && can_go) begin
				pend_v_q <= 1'b0;
			end
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: src/rle_palette_line_decompressor_top.sv
// Channel  Handshake             Payload
// input    in_valid / in_stall   func, stream_word, first
// output   out_valid / out_stall command, chan, channel_end, item_last
//
// Steps: the engine takes a word off the input queue, then unpacks in turn each
// 10-bit table symbol, length field, literal, compressed entry (the table read
// is registered) or terminator, and closes each table word and line word; a
// line word that arrives when all channels have ended is ignored. The decode
// engine takes a single step per cycle unless a stalled output holds it.
// Reset: arst_n clears all control state; table contents are undefined.
// Stalls: a two-entry queue holds input transactions while the engine works;
// a stalled output holds the engine only when it has a further result.
`default_nettype none
module rle_palette_line_decompressor_top import rpld_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        func,
	input  wire logic [31:0] stream_word,
	input  wire logic        first,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      command,
	output logic [1:0]       chan,
	output logic             channel_end,
	output logic             item_last
);

	entry_t in_entry;
	head_t  head;
	logic   pop;

	// bundle the payload for the queue
	assign in_entry = '{func: func, stream_word: stream_word, first: first};

	// front: accept and buffer input transactions
	rpld_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_entry (in_entry),
		.head     (head),
		.pop      (pop)
	);

	// back: unpack bits, fill tables, decode line commands
	rpld_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.command     (command),
		.chan        (chan),
		.channel_end (channel_end),
		.item_last   (item_last)
	);

endmodule
`default_nettype wire

// File: src/rpld_checker.sv
`default_nettype none
module rpld_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] command,
	input wire logic [1:0]  chan,
	input wire logic        channel_end
);

	// hold a stalled transaction
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(command))
		else $error("stalled output transaction changed");

	// a terminator carries a zero command
	a_term_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && channel_end |-> command == 32'h0)
		else $error("terminator with non-zero command");

	// only three colour channels exist
	a_chan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> chan != 2'd3)
		else $error("channel out of range");

	// decoded commands always carry a set prefix bit
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !channel_end |-> command[30] || command[31])
		else $error("command without prefix");

endmodule

bind rle_palette_line_decompressor_top rpld_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.command     (command),
	.chan        (chan),
	.channel_end (channel_end)
);
`default_nettype wire
